FILE: hdl/vbkd_pkg.sv
// Shared types, constants and helpers for the VIN-bound key derivation block.
`default_nettype none
package vbkd_pkg;

  localparam int NBYTES    = 16;
  localparam int BYTE_W    = 8;
  localparam int DSR_W     = BYTE_W + 1;      // divisor K[i]+i+1 spans 1..271
  localparam int DIV_STEPS = 2;               // restoring steps per lane stage
  localparam int NLSTG     = BYTE_W / DIV_STEPS;
  localparam int NSTG      = NLSTG + 4;       // front, bubble, lanes, swap, out
  localparam int BUB_SPLIT = 7;               // bubble steps done at the front
  localparam int SWP_SPLIT = 8;               // swap steps done in first merge stage

  localparam int ST_IN    = 0;
  localparam int ST_BUB   = 1;
  localparam int ST_LANE0 = 2;
  localparam int ST_SWP   = ST_LANE0 + NLSTG;
  localparam int ST_OUT   = ST_SWP + 1;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef byte_t [NBYTES-1:0] bytes_t;

  typedef struct packed {
    logic [NLSTG-1:0] adv;
  } lane_ctl_t;

  typedef struct packed {
    logic adv_swp;
    logic adv_out;
  } merge_ctl_t;

  typedef struct packed {
    byte_t              dvd;
    logic [DSR_W-1:0]   dsr;
    byte_t              sx;
    byte_t              key;
  } lane_in_t;

  typedef struct packed {
    byte_t iv;
    byte_t kk;
    byte_t key;
  } lane_out_t;

  // One restoring modulo step: shift in one dividend bit, subtract if it fits.
  function automatic logic [DSR_W-1:0] mod_step(logic [DSR_W-1:0] rem, logic bit_in,
                                                 logic [DSR_W-1:0] dsr);
    logic [DSR_W:0] t;
    t = {rem, bit_in};
    if (t >= {1'b0, dsr}) begin
      t = t - {1'b0, dsr};
    end
    return t[DSR_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/vbkd_mod_lane.sv
// One byte lane: pipelined restoring modulo k mod (K+i+1), then k' = iv ^ s.
`default_nettype none
module vbkd_mod_lane (
  input  wire logic                clk,
  input  wire vbkd_pkg::lane_ctl_t ctl,
  input  wire vbkd_pkg::lane_in_t  din,
  output vbkd_pkg::lane_out_t      dout
);

  logic [vbkd_pkg::DSR_W-1:0] rem_r [vbkd_pkg::NLSTG];
  vbkd_pkg::byte_t            dvd_r [vbkd_pkg::NLSTG];
  logic [vbkd_pkg::DSR_W-1:0] dsr_r [vbkd_pkg::NLSTG];
  vbkd_pkg::byte_t            sx_r  [vbkd_pkg::NLSTG];
  vbkd_pkg::byte_t            key_r [vbkd_pkg::NLSTG];

  for (genvar g = 0; g < vbkd_pkg::NLSTG; g++) begin : g_stg
    logic [vbkd_pkg::DSR_W-1:0] rem_in;
    vbkd_pkg::byte_t            dvd_in;
    logic [vbkd_pkg::DSR_W-1:0] dsr_in;
    vbkd_pkg::byte_t            sx_in;
    vbkd_pkg::byte_t            key_in;
    logic [vbkd_pkg::DSR_W-1:0] rem_nxt;
    vbkd_pkg::byte_t            dvd_nxt;

    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign dvd_in = din.dvd;
      assign dsr_in = din.dsr;
      assign sx_in  = din.sx;
      assign key_in = din.key;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign dvd_in = dvd_r[g-1];
      assign dsr_in = dsr_r[g-1];
      assign sx_in  = sx_r[g-1];
      assign key_in = key_r[g-1];
    end

    always_comb begin
      rem_nxt = rem_in;
      dvd_nxt = dvd_in;
      for (int j = 0; j < vbkd_pkg::DIV_STEPS; j++) begin
        rem_nxt = vbkd_pkg::mod_step(rem_nxt, dvd_nxt[vbkd_pkg::BYTE_W-1], dsr_in);
        dvd_nxt = {dvd_nxt[vbkd_pkg::BYTE_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv[g]) begin
        rem_r[g] <= rem_nxt;
        dvd_r[g] <= dvd_nxt;
        dsr_r[g] <= dsr_in;
        sx_r[g]  <= sx_in;
        key_r[g] <= key_in;
      end
    end
  end

  // remainder never exceeds the dividend, so it fits a byte
  assign dout.iv  = rem_r[vbkd_pkg::NLSTG-1][vbkd_pkg::BYTE_W-1:0];
  assign dout.kk  = rem_r[vbkd_pkg::NLSTG-1][vbkd_pkg::BYTE_W-1:0] ^ sx_r[vbkd_pkg::NLSTG-1];
  assign dout.key = key_r[vbkd_pkg::NLSTG-1];

endmodule
`default_nettype wire

FILE: hdl/vbkd_merge.sv
// Merge stages: odd-driven neighbor swap pass over iv and final byte mix.
`default_nettype none
module vbkd_merge (
  input  wire logic                 clk,
  input  wire vbkd_pkg::merge_ctl_t ctl,
  input  wire vbkd_pkg::bytes_t     iv,
  input  wire vbkd_pkg::bytes_t     kk,
  input  wire vbkd_pkg::bytes_t     key,
  output vbkd_pkg::bytes_t          res
);

  vbkd_pkg::bytes_t iv_r, kk_r, key_r, res_r;
  vbkd_pkg::bytes_t iv_nxt, res_nxt, iv_b;
  vbkd_pkg::byte_t  t;
  vbkd_pkg::byte_t  t_b;

  // first half of the swap pass
  always_comb begin
    iv_nxt = iv;
    t      = '0;
    for (int i = 0; i < vbkd_pkg::SWP_SPLIT; i++) begin
      if (kk[i][0]) begin
        t           = iv_nxt[i];
        iv_nxt[i]   = iv_nxt[i+1];
        iv_nxt[i+1] = t;
      end
    end
  end

  // rest of the swap pass, then out = K ^ (iv odd ? k : iv)
  always_comb begin
    iv_b = iv_r;
    t_b  = '0;
    for (int i = vbkd_pkg::SWP_SPLIT; i < vbkd_pkg::NBYTES - 1; i++) begin
      if (kk_r[i][0]) begin
        t_b       = iv_b[i];
        iv_b[i]   = iv_b[i+1];
        iv_b[i+1] = t_b;
      end
    end
    for (int i = 0; i < vbkd_pkg::NBYTES; i++) begin
      res_nxt[i] = key_r[i] ^ (iv_b[i][0] ? kk_r[i] : iv_b[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv_swp) begin
      iv_r  <= iv_nxt;
      kk_r  <= kk;
      key_r <= key;
    end
    if (ctl.adv_out) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

FILE: hdl/vin_bound_key_derivation.sv
// Top level of the VIN-bound key derivation block: pipeline control and front stages.
//
//   channel | ports                                   | dir | beat
//   --------+-----------------------------------------+-----+---------------------------
//   in      | in_valid/in_ready, in_key_lo/hi,        | in  | raw key + VIN bytes
//           | in_vin_lo/hi                            |     |
//   out     | out_valid/out_ready, out_derived_lo/hi  | out | derived 16-byte key
//
// Throughput: one beat per cycle while out_ready stays high. Each beat passes
// through eight register stages in order: front, bubble, the four-stage restoring
// modulo pipeline in each lane (two quotient bits per stage), swap and output.
// Reset: rst_n is synchronous, active low; it clears only the stage valid bits.
// Stalls: each stage advances when its successor is empty or advancing, so
// bubbles collapse; while a result waits at the output, input keeps flowing
// until all eight stages hold a beat, then in_ready drops.
`default_nettype none
module vin_bound_key_derivation (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_key_lo,
  input  wire logic [63:0] in_key_hi,
  input  wire logic [63:0] in_vin_lo,
  input  wire logic [63:0] in_vin_hi,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_derived_lo,
  output logic [63:0]      out_derived_hi
);

  localparam int NB = vbkd_pkg::NBYTES;

  // ---------------- pipeline control ----------------
  logic [vbkd_pkg::NSTG-1:0] vld_r, vld_nxt;
  logic [vbkd_pkg::NSTG:0]   rdy;
  logic [vbkd_pkg::NSTG-1:0] adv;

  always_comb begin
    rdy[vbkd_pkg::NSTG] = out_ready;
    for (int n = vbkd_pkg::NSTG - 1; n >= 0; n--) begin
      rdy[n] = !vld_r[n] || rdy[n+1];
    end
    adv[0] = rdy[0] && in_valid;
    for (int n = 1; n < vbkd_pkg::NSTG; n++) begin
      adv[n] = rdy[n] && vld_r[n-1];
    end
    for (int n = 0; n < vbkd_pkg::NSTG; n++) begin
      if (adv[n]) begin
        vld_nxt[n] = 1'b1;
      end else if (rdy[n+1]) begin
        vld_nxt[n] = 1'b0;     // content left, or stage was empty
      end else begin
        vld_nxt[n] = vld_r[n];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = vld_r[vbkd_pkg::ST_OUT];

  // ---------------- front stage: s, k, first part of bubble pass ----------------
  vbkd_pkg::bytes_t key_in, vin_in, s_a, k_a;
  vbkd_pkg::bytes_t key0_r, k0_r, s0_r;
  vbkd_pkg::byte_t  t;

  assign key_in = {in_key_hi, in_key_lo};
  assign vin_in = {in_vin_hi, in_vin_lo};   // vin_in[i] is V[i+1]

  always_comb begin
    t = '0;
    for (int i = 0; i < NB; i++) begin
      s_a[i] = vin_in[i] + vbkd_pkg::BYTE_W'(i);
      k_a[i] = key_in[i] ^ vin_in[NB-1-i];
    end
    for (int i = 0; i < vbkd_pkg::BUB_SPLIT; i++) begin
      if (s_a[i] > s_a[i+1]) begin
        t        = s_a[i];
        s_a[i]   = s_a[i+1];
        s_a[i+1] = t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[vbkd_pkg::ST_IN]) begin
      key0_r <= key_in;
      k0_r   <= k_a;
      s0_r   <= s_a;
    end
  end

  // ---------------- bubble stage: rest of the pass, then s ^= K+i ----------------
  vbkd_pkg::bytes_t s_b;
  vbkd_pkg::bytes_t key1_r, k1_r, sx1_r;
  vbkd_pkg::byte_t  u;

  always_comb begin
    s_b = s0_r;
    u   = '0;
    for (int i = vbkd_pkg::BUB_SPLIT; i < NB - 1; i++) begin
      if (s_b[i] > s_b[i+1]) begin
        u        = s_b[i];
        s_b[i]   = s_b[i+1];
        s_b[i+1] = u;
      end
    end
    for (int i = 0; i < NB; i++) begin
      s_b[i] = s_b[i] ^ (key0_r[i] + vbkd_pkg::BYTE_W'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[vbkd_pkg::ST_BUB]) begin
      key1_r <= key0_r;
      k1_r   <= k0_r;
      sx1_r  <= s_b;
    end
  end

  // ---------------- modulo lanes ----------------
  vbkd_pkg::lane_ctl_t lane_ctl;
  vbkd_pkg::bytes_t    iv_l, kk_l, key_l;

  assign lane_ctl.adv = adv[vbkd_pkg::ST_LANE0 +: vbkd_pkg::NLSTG];

  for (genvar g = 0; g < NB; g++) begin : g_lane
    vbkd_pkg::lane_in_t  lin;
    vbkd_pkg::lane_out_t lout;

    assign lin.dvd = k1_r[g];
    assign lin.dsr = {1'b0, key1_r[g]} + vbkd_pkg::DSR_W'(g + 1);
    assign lin.sx  = sx1_r[g];
    assign lin.key = key1_r[g];

    vbkd_mod_lane u_lane (
      .clk  (clk),
      .ctl  (lane_ctl),
      .din  (lin),
      .dout (lout)
    );

    assign iv_l[g]  = lout.iv;
    assign kk_l[g]  = lout.kk;
    assign key_l[g] = lout.key;
  end

  // ---------------- merge: swap pass and output register ----------------
  vbkd_pkg::merge_ctl_t mrg_ctl;
  vbkd_pkg::bytes_t     res;

  assign mrg_ctl.adv_swp = adv[vbkd_pkg::ST_SWP];
  assign mrg_ctl.adv_out = adv[vbkd_pkg::ST_OUT];

  vbkd_merge u_merge (
    .clk (clk),
    .ctl (mrg_ctl),
    .iv  (iv_l),
    .kk  (kk_l),
    .key (key_l),
    .res (res)
  );

  assign out_derived_lo = res[NB/2-1:0];
  assign out_derived_hi = res[NB-1:NB/2];

endmodule
`default_nettype wire

FILE: tb/vin_bound_key_derivation_test.sv
// Self-checking testbench for the VIN-bound key derivation block.

typedef struct packed {
  logic [63:0] lo;
  logic [63:0] hi;
} derived_key_t;

// Bit-exact prediction of one derived key from the raw key and the VIN bytes.
function automatic derived_key_t derive_key(logic [63:0] key_lo, logic [63:0] key_hi,
                                            logic [63:0] vin_lo, logic [63:0] vin_hi);
  vbkd_pkg::byte_t kb [vbkd_pkg::NBYTES];
  vbkd_pkg::byte_t vb [vbkd_pkg::NBYTES + 1];
  vbkd_pkg::byte_t sx [vbkd_pkg::NBYTES];
  vbkd_pkg::byte_t kx [vbkd_pkg::NBYTES];
  vbkd_pkg::byte_t rem [vbkd_pkg::NBYTES];
  vbkd_pkg::byte_t tmp;
  logic [8:0] divisor;
  derived_key_t r;
  vb[0] = '0;
  for (int i = 0; i < 8; i++) begin
    kb[i]     = key_lo[8*i +: 8];
    kb[i + 8] = key_hi[8*i +: 8];
    vb[i + 1] = vin_lo[8*i +: 8];
    vb[i + 9] = vin_hi[8*i +: 8];
  end
  for (int i = 0; i < vbkd_pkg::NBYTES; i++) begin
    sx[i] = vb[i + 1] + 8'(i);
    kx[i] = kb[i] ^ vb[vbkd_pkg::NBYTES - i];
  end
  // single ascending bubble pass
  for (int i = 0; i < vbkd_pkg::NBYTES - 1; i++) begin
    if (sx[i] > sx[i + 1]) begin
      tmp       = sx[i];
      sx[i]     = sx[i + 1];
      sx[i + 1] = tmp;
    end
  end
  for (int i = 0; i < vbkd_pkg::NBYTES; i++) begin
    divisor = {1'b0, kb[i]} + 9'(i + 1);
    rem[i]  = 8'({1'b0, kx[i]} % divisor);
    sx[i]   = sx[i] ^ (kb[i] + 8'(i));
    kx[i]   = rem[i] ^ sx[i];
  end
  // sequential swap, steered by the mixed byte's low bit
  for (int i = 0; i < vbkd_pkg::NBYTES - 1; i++) begin
    if (kx[i][0]) begin
      tmp        = rem[i];
      rem[i]     = rem[i + 1];
      rem[i + 1] = tmp;
    end
  end
  for (int i = 0; i < 8; i++) begin
    r.lo[8*i +: 8] = kb[i] ^ (rem[i][0] ? kx[i] : rem[i]);
    r.hi[8*i +: 8] = kb[i + 8] ^ (rem[i + 8][0] ? kx[i + 8] : rem[i + 8]);
  end
  return r;
endfunction

class key_scoreboard;
  derived_key_t awaited[$];
  int unsigned keys_in;
  int unsigned keys_out;
  int unsigned wide_divisor_keys;
  int unsigned mismatches;

  function void note_key(logic [63:0] key_lo, logic [63:0] key_hi,
                         logic [63:0] vin_lo, logic [63:0] vin_hi);
    logic [127:0] key;
    bit wide;
    key  = {key_hi, key_lo};
    wide = 1'b0;
    for (int i = 0; i < vbkd_pkg::NBYTES; i++)
      if (int'(key[8*i +: 8]) + i + 1 > 255) wide = 1'b1;
    if (wide) wide_divisor_keys++;
    awaited.push_back(derive_key(key_lo, key_hi, vin_lo, vin_hi));
    keys_in++;
  endfunction

  function void flag(string what, logic [63:0] want, logic [63:0] got);
    if (mismatches < 10)
      $display("mismatch on derived key %0d, %s: expected %h, got %h",
               keys_out, what, want, got);
    mismatches++;
  endfunction

  function void check_derived(logic [63:0] lo, logic [63:0] hi);
    derived_key_t want;
    keys_out++;
    if (awaited.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected derived key %0d: %h_%h", keys_out, hi, lo);
      mismatches++;
      return;
    end
    want = awaited.pop_front();
    if (lo !== want.lo) flag("derived_lo", want.lo, lo);
    if (hi !== want.hi) flag("derived_hi", want.hi, hi);
  endfunction

  function int unsigned pending();
    return awaited.size();
  endfunction
endclass

module vin_bound_key_derivation_test;

  localparam int RANDOM_KEYS = 550;
  localparam int HOLD_CYCLES = 80;    // long output back-pressure, fills the pipe
  localparam int TAIL_CYCLES = 16;    // margin after the last derived key comes back
  localparam int IDLE_LIMIT  = 2000;  // cycles without any beat before giving up

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_key_lo = '0;
  logic [63:0] in_key_hi = '0;
  logic [63:0] in_vin_lo = '0;
  logic [63:0] in_vin_hi = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_derived_lo;
  logic [63:0] out_derived_hi;

  key_scoreboard board = new();

  // Idle-mode flags: when clear, that side runs back to back.
  bit src_busy = 1'b1;
  bit sink_busy = 1'b1;
  bit sink_hold = 1'b0;   // one-shot request for a long output stall
  int burst_left = 0;     // beats the sender sends with no gaps
  int directed_keys = 0;
  int idle_cycles = 0;

  vin_bound_key_derivation dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_key_lo     (in_key_lo),
    .in_key_hi     (in_key_hi),
    .in_vin_lo     (in_vin_lo),
    .in_vin_hi     (in_vin_hi),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_derived_lo(out_derived_lo),
    .out_derived_hi(out_derived_hi)
  );

  always #1 clk = ~clk;

  // Watchdog: a long run of cycles with no beat on either side means a hang.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d derived keys still awaited",
                 IDLE_LIMIT, board.pending());
        $display("FAIL");
        $finish;
      end
    end
  end

  // Byte ramp: byte j of the word is base + step * (j + offset).
  function automatic logic [63:0] ramp(int base, int step, int offset);
    logic [63:0] w;
    for (int j = 0; j < 8; j++) w[8*j +: 8] = 8'(base + step * (j + offset));
    return w;
  endfunction

  // Byte picker biased toward the edges of the modulo step: zero keys give
  // tiny divisors, keys near 0xFF push the divisor past 255.
  function automatic logic [63:0] pick_word();
    logic [63:0] w;
    if ($urandom_range(0, 1) == 0) return {$urandom, $urandom};
    for (int j = 0; j < 8; j++) begin
      case ($urandom_range(0, 7))
        0:       w[8*j +: 8] = 8'h00;
        1:       w[8*j +: 8] = 8'hff;
        2:       w[8*j +: 8] = 8'($urandom_range(240, 255));
        3:       w[8*j +: 8] = 8'($urandom_range(0, 15));
        default: w[8*j +: 8] = 8'($urandom);
      endcase
    end
    return w;
  endfunction

  // Offer one beat and hold it until accepted. Called at a rising edge; on
  // return we sit at the accepting edge with in_valid still high.
  task automatic send_key(logic [63:0] key_lo, logic [63:0] key_hi,
                          logic [63:0] vin_lo, logic [63:0] vin_hi);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = src_busy ? $urandom_range(0, 10) : 0;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_key_lo <= key_lo;
    in_key_hi <= key_hi;
    in_vin_lo <= vin_lo;
    in_vin_hi <= vin_hi;
    do @(posedge clk); while (!in_ready);
    board.note_key(key_lo, key_hi, vin_lo, vin_hi);
    if ($urandom_range(0, 24) == 0) src_busy = !src_busy;
  endtask

  // Stop offering and wait until every derived key has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // Receiver: random stall before each beat, or one long hold on request.
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (sink_hold) begin
        stall     = HOLD_CYCLES;
        sink_hold = 1'b0;
      end else begin
        stall = sink_busy ? $urandom_range(0, 10) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      board.check_derived(out_derived_lo, out_derived_hi);
      if ($urandom_range(0, 30) == 0) sink_busy = !sink_busy;
    end
  end

  // Stimulus
  initial begin
    logic [63:0] kl, kh, vl, vh;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed keys: field extremes, divisor edges, full and empty bubble pass.
    send_key('0, '0, '0, '0);
    send_key('1, '1, '1, '1);
    send_key('1, '1, '0, '0);                         // every divisor above 255
    send_key('0, '0, '1, '1);                         // divisors 1..16
    send_key(ramp(255, -1, 0), ramp(255, -1, 8),      // divisor exactly 256
             {$urandom, $urandom}, {$urandom, $urandom});
    send_key(ramp(254, -1, 0), ramp(254, -1, 8),      // divisor exactly 255
             {$urandom, $urandom}, {$urandom, $urandom});
    send_key({$urandom, $urandom}, {$urandom, $urandom},
             ramp(240, -2, 0), ramp(240, -2, 8));     // s descending: every swap
    send_key({$urandom, $urandom}, {$urandom, $urandom},
             ramp(0, 3, 0), ramp(0, 3, 8));           // s ascending: no swap
    send_key(ramp(0, 1, 0), ramp(0, 1, 8), '1, '1);
    send_key({16{4'ha}}, {16{4'h5}}, {16{4'h5}}, {16{4'ha}});
    send_key({16{4'h5}}, {16{4'ha}}, {16{4'ha}}, {16{4'h5}});
    send_key({8{8'h01}}, {8{8'h01}}, {8{8'h80}}, {8{8'h80}});
    send_key({8{8'h80}}, {8{8'h7f}}, {8{8'h01}}, {8{8'hfe}});
    send_key(64'h8000_0000_0000_0001, 64'h0000_0000_0000_0080,
             64'h0100_0000_0000_00ff, 64'hff00_0000_0000_0001);
    directed_keys = board.keys_in;
    drain();

    for (int n = 0; n < RANDOM_KEYS; n++) begin
      if (n == 60) begin
        // Long output stall while input streams in: pipe fills, in_ready drops.
        sink_hold  = 1'b1;
        burst_left = 40;
      end
      if (n == 300) drain();
      kl = pick_word();
      kh = pick_word();
      vl = pick_word();
      vh = pick_word();
      send_key(kl, kh, vl, vh);
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Derived %0d keys (%0d directed, %0d random), %0d with a lane divisor above 255.",
             board.keys_in, directed_keys, board.keys_in - directed_keys,
             board.wide_divisor_keys);
    $display("Checked %0d results under random stalls, a long output hold and a full drain.",
             board.keys_out);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d derived keys never seen",
               board.mismatches, board.pending());
      $display("FAIL");
    end
    $finish;
  end

endmodule
